// File: src/tts_pkg.sv
`default_nettype none
package tts_pkg;
  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdxW = $clog2(MaxTasks);
  localparam int unsigned CntW = $clog2(MaxTasks + 1);

  typedef enum logic [1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_DELETE   = 2'd1,
    FUNC_TICK     = 2'd2,
    FUNC_DISPATCH = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NONEDUE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_TICK,
    S_DISP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [7:0]  handle;
    logic [7:0]  id;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } entry_t;
endpackage
`default_nettype wire

// File: src/tick_task_scheduler_table_core.sv
// add answers from idle; delete searches, then shifts down; tick and dispatch walk the table
// no item accepted while busy; a single shared update unit visits one entry per cycle,
// but a dispatch stalls its walk until each result, held in an output register, is taken
// reset clears the entry count and id counter; table contents need no clearing
`default_nettype none
module tick_task_scheduler_table_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // func[1:0], task_handle[9:2], first_delay[25:10], repeat_period[41:26], target_id[49:42]
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // status[1:0], run_handle[9:2], run_id[17:10]
  output logic [23:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);
  import tts_pkg::*;

  entry_t mem_q [MaxTasks];
  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0] nid_q, nid_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [7:0] tgt_q, tgt_d;
  logic ovalid_q, ovalid_d;
  logic [23:0] odata_q, odata_d;
  logic olast_q, olast_d;
  logic any_q, any_d;
  logic [23:0] hold_q, hold_d;
  logic we;
  logic [IdxW-1:0] waddr;
  entry_t wdata, cur, nxt;

  func_e fn;
  assign fn = func_e'(s_axis_tdata_i[1:0]);
  assign cur = mem_q[idx_q[IdxW-1:0]];
  assign nxt = (idx_q + 1'b1 < CntW'(MaxTasks)) ?
               mem_q[IdxW'(idx_q + 1'b1)] : cur;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; nid_d = nid_q; idx_d = idx_q; tgt_d = tgt_q;
    ovalid_d = ovalid_q; odata_d = odata_q; olast_d = olast_q; any_d = any_q;
    hold_d = hold_q;
    we = 1'b0; waddr = idx_q[IdxW-1:0]; wdata = cur;
    if (ovalid_q && m_axis_tready_i) ovalid_d = 1'b0;
    s_axis_tready_o = (state_q == S_IDLE) && !ovalid_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          idx_d = '0; any_d = 1'b0;
          tgt_d = s_axis_tdata_i[49:42];
          unique case (fn)
            FUNC_ADD: begin
              ovalid_d = 1'b1; olast_d = 1'b1;
              if (cnt_q >= CntW'(MaxTasks)) begin
                odata_d = {8'd0, 8'd0, 6'd0, ST_FULL};
              end else begin
                we = 1'b1; waddr = cnt_q[IdxW-1:0];
                wdata = '{handle: s_axis_tdata_i[9:2], id: nid_q,
                          delay: s_axis_tdata_i[25:10],
                          period: s_axis_tdata_i[41:26], pending: 8'd0};
                odata_d = {6'd0, nid_q, s_axis_tdata_i[9:2], ST_OK};
                cnt_d = cnt_q + 1'b1; nid_d = nid_q + 8'd1;
              end
            end
            FUNC_DELETE: state_d = S_SEARCH;
            FUNC_TICK: state_d = S_TICK;
            FUNC_DISPATCH: state_d = S_DISP;
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (idx_q >= cnt_q) begin
          ovalid_d = 1'b1; olast_d = 1'b1;
          odata_d = {8'd0, 8'd0, 6'd0, ST_NOTFOUND};
          state_d = S_OUT;
        end else if (cur.id == tgt_q) begin
          odata_d = {6'd0, cur.id, cur.handle, ST_OK};
          state_d = S_SHIFT;
        end else idx_d = idx_q + 1'b1;
      end
      S_SHIFT: begin
        if (idx_q + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          ovalid_d = 1'b1; olast_d = 1'b1;
          state_d = S_OUT;
        end else begin
          we = 1'b1; wdata = nxt; idx_d = idx_q + 1'b1;
        end
      end
      S_TICK: begin
        if (idx_q >= cnt_q) state_d = S_IDLE;
        else begin
          we = 1'b1;
          if (cur.delay != 16'd0) wdata.delay = cur.delay - 16'd1;
          else begin
            wdata.delay = cur.period;
            if (cur.pending != 8'hFF) wdata.pending = cur.pending + 8'd1;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      S_DISP: begin
        if (!ovalid_q || m_axis_tready_i) begin
          if (idx_q >= cnt_q) begin
            ovalid_d = 1'b1; olast_d = 1'b1; state_d = S_OUT;
            if (any_q) odata_d = hold_q;
            else odata_d = {8'd0, 8'd0, 6'd0, ST_NONEDUE};
          end else if (cur.pending != 8'd0) begin
            if (any_q) begin
              ovalid_d = 1'b1; olast_d = 1'b0; odata_d = hold_q;
            end
            we = 1'b1; wdata.pending = cur.pending - 8'd1;
            hold_d = {6'd0, cur.id, cur.handle, ST_OK};
            any_d = 1'b1;
            idx_d = idx_q + 1'b1;
          end else idx_d = idx_q + 1'b1;
        end
      end
      S_OUT: begin
        if (!ovalid_d) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; nid_q <= '0; ovalid_q <= 1'b0;
      idx_q <= '0; any_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; nid_q <= nid_d; ovalid_q <= ovalid_d;
      idx_q <= idx_d; any_q <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d; odata_q <= odata_d; olast_q <= olast_d; hold_q <= hold_d;
    if (we) mem_q[waddr] <= wdata;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxTasks)) else $error("entry count out of range");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready_o) else $error("ready while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

// File: sim/tick_task_scheduler_table_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module tick_task_scheduler_table_checker
  import tts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [55:0] s_axis_tdata_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [23:0] m_axis_tdata_i,
  input  wire logic        m_axis_tlast_i,
  output int               fail_count_o,
  output int               awaited_o,
  output int               items_seen_o,
  output int               results_seen_o
);

  typedef struct packed {
    status_e    status;
    logic [7:0] handle;
    logic [7:0] id;
    logic       last;
  } sched_result_t;

  logic [7:0]  tbl_handle [MaxTasks];
  logic [7:0]  tbl_id [MaxTasks];
  logic [15:0] tbl_delay [MaxTasks];
  logic [15:0] tbl_period [MaxTasks];
  logic [7:0]  tbl_pending [MaxTasks];
  int          tbl_count;
  logic [7:0]  id_counter;

  sched_result_t awaited_runs[$];

  function automatic sched_result_t mk(status_e st, logic [7:0] h, logic [7:0] id, logic lst);
    sched_result_t r;
    r.status = st;
    r.handle = h;
    r.id = id;
    r.last = lst;
    return r;
  endfunction

  task automatic schedule_item(input logic [55:0] d);
    func_e       op;
    logic [7:0]  h;
    logic [15:0] dly;
    logic [15:0] per;
    logic [7:0]  tgt;
    int          n;
    int          hit;
    op  = func_e'(d[1:0]);
    h   = d[9:2];
    dly = d[25:10];
    per = d[41:26];
    tgt = d[49:42];
    case (op)
      FUNC_ADD: begin
        if (tbl_count >= MaxTasks) begin
          awaited_runs.push_back(mk(ST_FULL, 8'd0, 8'd0, 1'b1));
        end else begin
          tbl_handle[tbl_count] = h;
          tbl_id[tbl_count] = id_counter;
          tbl_delay[tbl_count] = dly;
          tbl_period[tbl_count] = per;
          tbl_pending[tbl_count] = 8'd0;
          tbl_count++;
          awaited_runs.push_back(mk(ST_OK, h, id_counter, 1'b1));
          id_counter++;
        end
      end
      FUNC_DELETE: begin
        hit = -1;
        for (int i = 0; i < tbl_count; i++)
          if (hit < 0 && tbl_id[i] == tgt) hit = i;
        if (hit < 0) begin
          awaited_runs.push_back(mk(ST_NOTFOUND, 8'd0, 8'd0, 1'b1));
        end else begin
          awaited_runs.push_back(mk(ST_OK, tbl_handle[hit], tbl_id[hit], 1'b1));
          for (int j = hit; j + 1 < tbl_count; j++) begin
            tbl_handle[j] = tbl_handle[j+1];
            tbl_id[j] = tbl_id[j+1];
            tbl_delay[j] = tbl_delay[j+1];
            tbl_period[j] = tbl_period[j+1];
            tbl_pending[j] = tbl_pending[j+1];
          end
          tbl_count--;
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_delay[i] != 16'd0) begin
            tbl_delay[i] = tbl_delay[i] - 16'd1;
          end else begin
            tbl_delay[i] = tbl_period[i];
            if (tbl_pending[i] != 8'hff) tbl_pending[i] = tbl_pending[i] + 8'd1;
          end
        end
      end
      default: begin
        n = 0;
        for (int i = 0; i < tbl_count && n < 16; i++) begin
          if (tbl_pending[i] != 8'd0) begin
            tbl_pending[i] = tbl_pending[i] - 8'd1;
            awaited_runs.push_back(mk(ST_OK, tbl_handle[i], tbl_id[i], 1'b0));
            n++;
          end
        end
        if (n == 0) awaited_runs.push_back(mk(ST_NONEDUE, 8'd0, 8'd0, 1'b1));
        else awaited_runs[$].last = 1'b1;
      end
    endcase
  endtask

  task automatic check_run(input logic [23:0] d, input logic lst);
    sched_result_t exp_r;
    if (awaited_runs.size() == 0) begin
      $error("unexpected result: tdata %h tlast %b", d, lst);
      fail_count_o++;
    end else begin
      exp_r = awaited_runs.pop_front();
      if (d[1:0] !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, d[1:0]);
        fail_count_o++;
      end
      if (d[9:2] !== exp_r.handle) begin
        $error("run_handle: expected %0d, got %0d", exp_r.handle, d[9:2]);
        fail_count_o++;
      end
      if (d[17:10] !== exp_r.id) begin
        $error("run_id: expected %0d, got %0d", exp_r.id, d[17:10]);
        fail_count_o++;
      end
      if (lst !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, lst);
        fail_count_o++;
      end
    end
  endtask

  initial begin
    fail_count_o = 0;
    items_seen_o = 0;
    results_seen_o = 0;
    tbl_count = 0;
    id_counter = 8'd0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_count = 0;
      id_counter = 8'd0;
      awaited_runs.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_run(m_axis_tdata_i, m_axis_tlast_i);
        results_seen_o++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        schedule_item(s_axis_tdata_i);
        items_seen_o++;
      end
    end
  end

  assign awaited_o = awaited_runs.size();

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import tts_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // func, task_handle, first_delay, repeat_period, target_id
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // status, run_handle, run_id
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          awaited;
  int          items_seen;
  int          results_seen;
  int          cycle_count;
  int          items_sent;
  logic [7:0]  live_ids[$];
  logic [7:0]  next_tag;
  logic        hold_done;

  tick_task_scheduler_table_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  tick_task_scheduler_table_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tlast_i (m_axis_tlast),
    .fail_count_o   (fail_count),
    .awaited_o      (awaited),
    .items_seen_o   (items_seen),
    .results_seen_o (results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input func_e op, input logic [7:0] h, input logic [15:0] dly,
                      input logic [15:0] per, input logic [7:0] tgt);
    int g;
    int idx;
    if (op == FUNC_ADD && live_ids.size() < MaxTasks) begin
      live_ids.push_back(next_tag);
      next_tag++;
    end
    if (op == FUNC_DELETE) begin
      idx = -1;
      foreach (live_ids[i]) if (idx < 0 && live_ids[i] == tgt) idx = i;
      if (idx >= 0) live_ids.delete(idx);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, tgt, per, dly, h, op};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    int r;
    logic [15:0] dly;
    logic [15:0] per;
    logic [7:0]  tgt;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      dly = 16'($urandom);
      per = 16'($urandom);
    end else begin
      dly = 16'($urandom_range(0, 6));
      per = 16'($urandom_range(0, 6));
    end
    if (live_ids.size() > 0 && $urandom_range(0, 9) < 8)
      tgt = live_ids[$urandom_range(0, live_ids.size() - 1)];
    else
      tgt = 8'($urandom);
    if (r < 28) send(FUNC_ADD, 8'($urandom), dly, per, 8'($urandom));
    else if (r < 45) send(FUNC_DELETE, 8'($urandom), 16'($urandom), 16'($urandom), tgt);
    else if (r < 80) send(FUNC_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                          8'($urandom));
    else send(FUNC_DISPATCH, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // receiver back-pressure, with one long hold-off once traffic is under way
  initial begin
    int g;
    m_axis_tready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      if (!hold_done && items_sent > 100) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 3000000) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int settle;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    items_sent = 0;
    next_tag = 8'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table
    send(FUNC_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0);
    send(FUNC_DELETE, 8'd0, 16'd0, 16'd0, 8'hff);
    send(FUNC_TICK, 8'd0, 16'd0, 16'd0, 8'd0);

    // full table and a dispatch of every entry
    for (int k = 0; k < MaxTasks; k++)
      send(FUNC_ADD, (k == 0) ? 8'hff : k[7:0], 16'd0, (k == 1) ? 16'hffff : 16'd1, 8'd0);
    send(FUNC_ADD, 8'h5a, 16'hffff, 16'hffff, 8'd0);
    send(FUNC_TICK, 8'd0, 16'd0, 16'd0, 8'd0);
    send(FUNC_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0);
    send(FUNC_DISPATCH, 8'd0, 16'd0, 16'd0, 8'd0);
    send(FUNC_DELETE, 8'd0, 16'd0, 16'd0, 8'd0);

    // random traffic
    repeat (275) send_random();
    s_axis_tvalid <= 1'b0;

    while (awaited != 0) @(posedge clk_i);
    settle = 0;
    while (settle < 64) begin
      @(posedge clk_i);
      settle++;
    end
    $display("ran %0d items through add, delete, tick and dispatch, %0d results compared",
             items_seen, results_seen);
    $display("empty table, full table, full dispatch walk and a long output stall covered");
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: tick_task_scheduler_table_core.f
src/tts_pkg.sv
src/tick_task_scheduler_table_core.sv
sim/tick_task_scheduler_table_checker.sv
sim/testbench.sv
